FILE: design/urs_pkg.sv
// ----------------------------------------------------------------------------
// urs_pkg
// Shared types, constants and lookup tables for the ultrasonic range to servo
// block: phase codes, register indexes, timing constants and the distance to
// angle and compare tables.
// ----------------------------------------------------------------------------
package urs_pkg;

  typedef enum logic [2:0] {
    PH_TRIG_LOW  = 3'd0,
    PH_TRIG_HIGH = 3'd1,
    PH_WAIT      = 3'd2,
    PH_MEASURE   = 3'd3,
    PH_PAUSE     = 3'd4
  } phase_t;

  localparam logic [0:0] CFG_TIMEOUT = 1'b0;
  localparam logic [0:0] CFG_PAUSE   = 1'b1;

  localparam int TimeoutW = 16;
  localparam int PauseW   = 20;
  localparam int CfgDataW = 20;
  localparam int TickW    = 20;
  localparam int EchoW    = 17;
  localparam int DistW    = 6;
  localparam int AngleW   = 8;
  localparam int CmpW     = 12;

  localparam logic [TimeoutW-1:0] TIMEOUT_RESET = 16'd30000;
  localparam logic [PauseW-1:0]   PAUSE_RESET   = 20'd50000;

  localparam logic [TickW-1:0] TRIG_LOW_TICKS  = 20'd2;
  localparam logic [TickW-1:0] TRIG_HIGH_TICKS = 20'd10;

  localparam int UsPerCm  = 58;
  localparam int DistMin  = 5;
  localparam int DistMax  = 40;
  localparam int DistSpan = 35;
  localparam int AngleMax = 180;
  localparam int CmpBase  = 2000;
  localparam int CmpSpan  = 2000;

  // counts at or above this always clamp to the maximum distance
  localparam logic [EchoW-1:0] ECHO_SAT = 17'((DistMax + 1) * UsPerCm);
  // reciprocal of 58 in 16 fractional bits, exact for counts below ECHO_SAT
  localparam logic [10:0] RECIP_58 = 11'd1130;

  localparam logic [DistW-1:0]  DIST_MIN    = 6'(DistMin);
  localparam logic [DistW-1:0]  DIST_MAX    = 6'(DistMax);
  localparam logic [AngleW-1:0] ANGLE_RESET = 8'(AngleMax);
  localparam logic [CmpW-1:0]   CMP_RESET   = 12'd3000;

  localparam int TabN = DistSpan + 1;

  typedef logic [AngleW-1:0] angle_tab_t [0:TabN-1];
  typedef logic [CmpW-1:0]   cmp_tab_t   [0:TabN-1];

  function automatic angle_tab_t build_angle_tab();
    angle_tab_t tab;
    for (int i = 0; i < TabN; i++) begin
      tab[i] = 8'((i * AngleMax) / DistSpan);
    end
    return tab;
  endfunction

  function automatic cmp_tab_t build_cmp_tab();
    cmp_tab_t tab;
    int       a;
    for (int i = 0; i < TabN; i++) begin
      a = (i * AngleMax) / DistSpan;
      tab[i] = 12'(CmpBase + (a * CmpSpan) / AngleMax);
    end
    return tab;
  endfunction

  localparam angle_tab_t ANGLE_TAB = build_angle_tab();
  localparam cmp_tab_t   CMP_TAB   = build_cmp_tab();

endpackage

FILE: design/ultrasonic_range_to_servo.sv
// ----------------------------------------------------------------------------
// ultrasonic_range_to_servo
// Ultrasonic echo ranging sequencer with distance to servo compare mapping.
//
// Usage: each input request is one microsecond tick carrying the sampled echo
// pin level. The block steps trigger low (2 ticks), trigger high (10 ticks),
// wait for echo, count echo-high ticks and then pauses for pause_ticks ticks.
// Every input request produces exactly one output request carrying the
// trigger level for that tick, a done flag for the tick a measurement ends,
// and the latest timeout flag, distance (5..40 cm), angle (0..180 degrees)
// and servo compare value (2000..4000).
// Output valid rises in the cycle after input acceptance; throughput is one
// request per cycle while out_ready holds, set by the single registered pass
// from the phase and counter registers to the output register.
// When the receiver stalls, the output register holds its request and the
// input is taken only when the output register is empty or being drained.
// Reset (synchronous, rst_n low) returns to the trigger low phase, clears the
// counters, sets distance 40, angle 180, compare 3000, and loads the register
// defaults timeout_ticks 30000 and pause_ticks 50000. Configuration writes
// take effect at the next clock edge.
// ----------------------------------------------------------------------------
module ultrasonic_range_to_servo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [urs_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_echo_level,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_trig_level,
  output logic                       out_done_res,
  output logic                       out_timed_out,
  output logic [urs_pkg::DistW-1:0]  out_distance_cm,
  output logic [urs_pkg::AngleW-1:0] out_angle_deg,
  output logic [urs_pkg::CmpW-1:0]   out_servo_compare
);
  import urs_pkg::*;

  logic [TimeoutW-1:0] timeout_r;
  logic [PauseW-1:0]   pause_r;

  phase_t            phase_r, phase_nxt, phase_eff;
  logic [TickW-1:0]  tick_r, tick_nxt, tick_base, tick_inc;
  logic [EchoW-1:0]  echo_r, echo_nxt, echo_inc;
  logic              finish, finish_to;

  logic              timed_out_r, timed_out_nxt;
  logic [DistW-1:0]  dist_r, dist_nxt;
  logic [AngleW-1:0] angle_r;
  logic [CmpW-1:0]   cmp_r;

  logic              out_valid_r, trig_r, done_r;
  logic              trig_nxt, done_nxt;
  logic              accept;

  logic [22:0]       quot_prod;
  logic [6:0]        quot;
  logic [DistW-1:0]  dist_calc, tab_idx;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      pause_r   <= PAUSE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT: timeout_r <= cfg_wdata[TimeoutW-1:0];
        CFG_PAUSE:   pause_r   <= cfg_wdata[PauseW-1:0];
        default: ;
      endcase
    end
  end

  // echo count to centimetres, clamped to the valid range
  always_comb begin
    quot_prod = 23'(echo_r[11:0] * RECIP_58);
    quot      = quot_prod[22:16];
    if (echo_r >= ECHO_SAT) begin
      dist_calc = DIST_MAX;
    end else if (quot < 7'(DIST_MIN)) begin
      dist_calc = DIST_MIN;
    end else if (quot > 7'(DIST_MAX)) begin
      dist_calc = DIST_MAX;
    end else begin
      dist_calc = quot[DistW-1:0];
    end
  end

  // next state
  always_comb begin
    phase_eff = phase_r;
    tick_base = tick_r;
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    echo_nxt  = echo_r;
    finish    = 1'b0;
    finish_to = 1'b0;
    if (phase_r == PH_PAUSE) begin
      if (tick_r >= pause_r) begin
        phase_eff = PH_TRIG_LOW;
        tick_base = '0;
      end else begin
        tick_nxt = tick_r + 1'b1;
      end
    end
    tick_inc = tick_base + 1'b1;
    echo_inc = echo_r + 1'b1;
    case (phase_eff)
      PH_PAUSE: ;
      PH_TRIG_HIGH: begin
        if (tick_inc >= TRIG_HIGH_TICKS) begin
          phase_nxt = PH_WAIT;
          tick_nxt  = '0;
          echo_nxt  = '0;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      PH_WAIT: begin
        if (in_echo_level) begin
          echo_nxt  = EchoW'(1);
          phase_nxt = PH_MEASURE;
          finish_to = (timeout_r == '0);
        end else begin
          echo_nxt  = echo_inc;
          finish_to = (echo_inc > EchoW'(timeout_r));
        end
        finish = finish_to;
      end
      PH_MEASURE: begin
        if (in_echo_level) begin
          echo_nxt  = echo_inc;
          finish_to = (echo_inc > EchoW'(timeout_r));
          finish    = finish_to;
        end else begin
          finish = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_TRIG_LOW;
        if (tick_inc >= TRIG_LOW_TICKS) begin
          phase_nxt = PH_TRIG_HIGH;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_inc;
        end
      end
    endcase
    if (finish) begin
      phase_nxt = PH_PAUSE;
      tick_nxt  = '0;
      echo_nxt  = '0;
    end
    timed_out_nxt = finish_to || (echo_r == '0);
    dist_nxt      = timed_out_nxt ? DIST_MAX : dist_calc;
    tab_idx       = dist_nxt - DIST_MIN;
  end

  // per-tick outputs
  always_comb begin
    trig_nxt = (phase_eff == PH_TRIG_HIGH);
    done_nxt = finish;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TRIG_LOW;
      tick_r      <= '0;
      echo_r      <= '0;
      timed_out_r <= 1'b0;
      dist_r      <= DIST_MAX;
      angle_r     <= ANGLE_RESET;
      cmp_r       <= CMP_RESET;
      out_valid_r <= 1'b0;
      trig_r      <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        tick_r  <= tick_nxt;
        echo_r  <= echo_nxt;
        trig_r  <= trig_nxt;
        done_r  <= done_nxt;
        if (finish) begin
          timed_out_r <= timed_out_nxt;
          dist_r      <= dist_nxt;
          angle_r     <= ANGLE_TAB[tab_idx];
          cmp_r       <= CMP_TAB[tab_idx];
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_trig_level    = trig_r;
  assign out_done_res      = done_r;
  assign out_timed_out     = timed_out_r;
  assign out_distance_cm   = dist_r;
  assign out_angle_deg     = angle_r;
  assign out_servo_compare = cmp_r;

endmodule

FILE: tb/ultrasonic_range_to_servo_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ultrasonic_range_to_servo_test
// Self-checking bench for the echo ranging sequencer. A short table walks the
// trigger pulse, a one-tick echo, a zero-pause restart and a zero-timeout
// wait. Random phases follow under several timeout and pause settings: echo
// pulses are shaped from the predicted phase, with noise on top. Every tick
// request is checked field by field against its table row or an in-bench
// phase and counter predictor, with random idle cycles on both handshakes.
// ----------------------------------------------------------------------------
module ultrasonic_range_to_servo_test;
  import urs_pkg::*;

  typedef struct packed {
    logic              trig;
    logic              done;
    logic              timed;
    logic [DistW-1:0]  dist_cm;
    logic [AngleW-1:0] angle;
    logic [CmpW-1:0]   cmp;
  } tick_result_t;

  typedef enum logic [1:0] {
    ROW_TICK    = 2'd0,
    ROW_TIMEOUT = 2'd1,
    ROW_PAUSE   = 2'd2
  } row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    logic         echo;
    logic [19:0]  value;
    logic         typed;
    tick_result_t want;
  } plan_row_t;

  localparam tick_result_t NO_RESULT   = '0;
  localparam tick_result_t AT_RESET_LO =
    '{1'b0, 1'b0, 1'b0, DIST_MAX, ANGLE_RESET, CMP_RESET};
  localparam tick_result_t AT_RESET_HI =
    '{1'b1, 1'b0, 1'b0, DIST_MAX, ANGLE_RESET, CMP_RESET};
  localparam tick_result_t NEAREST_DONE =
    '{1'b0, 1'b1, 1'b0, DIST_MIN, 8'd0, 12'(CmpBase)};
  localparam tick_result_t TIMEOUT_DONE =
    '{1'b0, 1'b1, 1'b1, DIST_MAX, ANGLE_RESET, 12'(CmpBase + CmpSpan)};

  localparam int PlanN = 31;
  localparam plan_row_t DIRECTED [PlanN] = '{
    '{ROW_TICK,    1'b0, 20'd0, 1'b1, AT_RESET_LO},
    '{ROW_TICK,    1'b1, 20'd0, 1'b1, AT_RESET_LO},
    '{ROW_TICK,    1'b1, 20'd0, 1'b1, AT_RESET_HI},
    '{ROW_TICK,    1'b0, 20'd0, 1'b1, AT_RESET_HI},
    '{ROW_TICK,    1'b1, 20'd0, 1'b1, AT_RESET_HI},
    '{ROW_TICK,    1'b0, 20'd0, 1'b1, AT_RESET_HI},
    '{ROW_TICK,    1'b1, 20'd0, 1'b1, AT_RESET_HI},
    '{ROW_TICK,    1'b0, 20'd0, 1'b1, AT_RESET_HI},
    '{ROW_TICK,    1'b1, 20'd0, 1'b1, AT_RESET_HI},
    '{ROW_TICK,    1'b0, 20'd0, 1'b1, AT_RESET_HI},
    '{ROW_TICK,    1'b1, 20'd0, 1'b1, AT_RESET_HI},
    '{ROW_TICK,    1'b0, 20'd0, 1'b1, AT_RESET_HI},
    // echo seen high in the first wait tick
    '{ROW_TICK,    1'b1, 20'd0, 1'b1, AT_RESET_LO},
    // echo ends after one high tick
    '{ROW_TICK,    1'b0, 20'd0, 1'b1, NEAREST_DONE},
    '{ROW_PAUSE,   1'b0, 20'd0, 1'b0, NO_RESULT},
    '{ROW_TIMEOUT, 1'b0, 20'd0, 1'b0, NO_RESULT},
    '{ROW_TICK,    1'b1, 20'd0, 1'b0, NO_RESULT},
    '{ROW_TICK,    1'b0, 20'd0, 1'b0, NO_RESULT},
    '{ROW_TICK,    1'b0, 20'd0, 1'b0, NO_RESULT},
    '{ROW_TICK,    1'b1, 20'd0, 1'b0, NO_RESULT},
    '{ROW_TICK,    1'b0, 20'd0, 1'b0, NO_RESULT},
    '{ROW_TICK,    1'b1, 20'd0, 1'b0, NO_RESULT},
    '{ROW_TICK,    1'b0, 20'd0, 1'b0, NO_RESULT},
    '{ROW_TICK,    1'b1, 20'd0, 1'b0, NO_RESULT},
    '{ROW_TICK,    1'b0, 20'd0, 1'b0, NO_RESULT},
    '{ROW_TICK,    1'b1, 20'd0, 1'b0, NO_RESULT},
    '{ROW_TICK,    1'b0, 20'd0, 1'b0, NO_RESULT},
    '{ROW_TICK,    1'b1, 20'd0, 1'b0, NO_RESULT},
    // zero timeout ends the first wait tick
    '{ROW_TICK,    1'b0, 20'd0, 1'b1, TIMEOUT_DONE},
    '{ROW_PAUSE,   1'b0, 20'd3, 1'b0, NO_RESULT},
    '{ROW_TIMEOUT, 1'b0, 20'd30000, 1'b0, NO_RESULT}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [0:0]           cfg_index = CFG_TIMEOUT;
  logic [CfgDataW-1:0]  cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_echo_level = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_trig_level;
  logic                 out_done_res;
  logic                 out_timed_out;
  logic [DistW-1:0]     out_distance_cm;
  logic [AngleW-1:0]    out_angle_deg;
  logic [CmpW-1:0]      out_servo_compare;

  // predictor state and register copies
  phase_t               rng_phase = PH_TRIG_LOW;
  logic [TickW-1:0]     tick_cnt = '0;
  logic [EchoW-1:0]     echo_cnt = '0;
  logic [DistW-1:0]     last_dist = DIST_MAX;
  logic [AngleW-1:0]    last_angle = ANGLE_RESET;
  logic [CmpW-1:0]      last_cmp = CMP_RESET;
  logic                 last_timed = 1'b0;
  logic [TimeoutW-1:0]  timeout_lim = TIMEOUT_RESET;
  logic [PauseW-1:0]    pause_len = PAUSE_RESET;

  tick_result_t         pending_ticks [$];
  tick_result_t         oldest_tick;
  int unsigned          mismatch_count = 0;
  int unsigned          calm_in = 0;
  int unsigned          calm_out = 0;
  int unsigned          echo_delay_ticks = 0;
  int unsigned          echo_width_ticks = 0;
  int unsigned          long_echo_left = 4;

  ultrasonic_range_to_servo u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_echo_level     (in_echo_level),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_trig_level    (out_trig_level),
    .out_done_res      (out_done_res),
    .out_timed_out     (out_timed_out),
    .out_distance_cm   (out_distance_cm),
    .out_angle_deg     (out_angle_deg),
    .out_servo_compare (out_servo_compare)
  );

  always #5 clk = ~clk;

  function automatic void close_measurement(input bit timed);
    int d;
    int a;
    if (timed || echo_cnt == 0) begin
      d = DistMax;
      last_timed = 1'b1;
    end else begin
      d = echo_cnt / UsPerCm;
      last_timed = 1'b0;
    end
    if (d < DistMin) d = DistMin;
    if (d > DistMax) d = DistMax;
    a = ((d - DistMin) * AngleMax) / DistSpan;
    if (a > AngleMax) a = AngleMax;
    last_dist = DistW'(d);
    last_angle = AngleW'(a);
    last_cmp = CmpW'(CmpBase + (a * CmpSpan) / AngleMax);
    rng_phase = PH_PAUSE;
    tick_cnt = '0;
    echo_cnt = '0;
  endfunction

  function automatic tick_result_t advance_ranger(input logic echo);
    tick_result_t r;
    r = '0;
    if (rng_phase == PH_PAUSE) begin
      if (tick_cnt >= pause_len) begin
        rng_phase = PH_TRIG_LOW;
        tick_cnt = '0;
      end else begin
        tick_cnt = tick_cnt + 1'b1;
      end
    end
    case (rng_phase)
      PH_PAUSE: ;
      PH_TRIG_HIGH: begin
        r.trig = 1'b1;
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= TRIG_HIGH_TICKS) begin
          rng_phase = PH_WAIT;
          tick_cnt = '0;
          echo_cnt = '0;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          echo_cnt = EchoW'(1);
          rng_phase = PH_MEASURE;
        end else begin
          echo_cnt = echo_cnt + 1'b1;
        end
        if (echo_cnt > timeout_lim) begin
          close_measurement(1'b1);
          r.done = 1'b1;
        end
      end
      PH_MEASURE: begin
        if (echo) begin
          echo_cnt = echo_cnt + 1'b1;
          if (echo_cnt > timeout_lim) begin
            close_measurement(1'b1);
            r.done = 1'b1;
          end
        end else begin
          close_measurement(1'b0);
          r.done = 1'b1;
        end
      end
      default: begin
        rng_phase = PH_TRIG_LOW;
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= TRIG_LOW_TICKS) begin
          rng_phase = PH_TRIG_HIGH;
          tick_cnt = '0;
        end
      end
    endcase
    r.timed = last_timed;
    r.dist_cm = last_dist;
    r.angle = last_angle;
    r.cmp = last_cmp;
    return r;
  endfunction

  // idle stretches with occasional runs of back-to-back requests
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 40) == 0) calm = $urandom_range(20, 80);
    return $urandom_range(0, 18);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic send_tick(input logic echo, input logic typed, input tick_result_t want);
    int unsigned  gap;
    tick_result_t predicted;
    gap = draw_gap(calm_in);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_echo_level <= echo;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = advance_ranger(echo);
    pending_ticks.push_back(typed ? want : predicted);
  endtask

  task automatic write_reg_idle(input logic [0:0] idx, input logic [CfgDataW-1:0] data);
    in_valid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TIMEOUT) timeout_lim = data[TimeoutW-1:0];
    else pause_len = data[PauseW-1:0];
  endtask

  task automatic run_settings(input logic [TimeoutW-1:0] timeout_val,
                              input logic [PauseW-1:0] pause_val,
                              input int unsigned n_ticks);
    int unsigned sent;
    logic        e;
    write_reg_idle(CFG_TIMEOUT, {4'($urandom), timeout_val});
    write_reg_idle(CFG_PAUSE, pause_val);
    sent = 0;
    while (sent < n_ticks || rng_phase == PH_WAIT || rng_phase == PH_MEASURE) begin
      case (rng_phase)
        PH_WAIT:    e = (echo_cnt >= echo_delay_ticks);
        PH_MEASURE: e = (echo_cnt < echo_width_ticks);
        default: begin
          e = 1'($urandom_range(0, 1));
          // new pulse shape at the start of each trigger pulse
          if (rng_phase == PH_TRIG_HIGH && tick_cnt == 0) begin
            echo_delay_ticks = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 6)
                                                          : $urandom_range(0, 40);
            if ($urandom_range(0, 29) == 0 && long_echo_left != 0 &&
                timeout_lim >= 16'd300) begin
              echo_width_ticks = $urandom_range(280, 2500);
              long_echo_left--;
            end else begin
              echo_width_ticks = $urandom_range(0, 12);
            end
          end
        end
      endcase
      if ($urandom_range(0, 49) == 0) e = !e;
      send_tick(e, 1'b0, NO_RESULT);
      sent++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < PlanN; i++) begin
      case (DIRECTED[i].kind)
        ROW_TIMEOUT: write_reg_idle(CFG_TIMEOUT, DIRECTED[i].value);
        ROW_PAUSE:   write_reg_idle(CFG_PAUSE, DIRECTED[i].value);
        default:     send_tick(DIRECTED[i].echo, DIRECTED[i].typed, DIRECTED[i].want);
      endcase
    end
    run_settings(16'd0, 20'd0, 60);
    run_settings(16'd1, 20'd1, 120);
    run_settings(16'hFFFF, 20'd2, 400);
    run_settings(16'd4, 20'hFFFFF, 40);
    run_settings(16'($urandom_range(2, 40)), 20'($urandom_range(0, 20)), 300);
    run_settings(16'd3000, 20'd0, 400);
    run_settings(16'($urandom_range(1, 65535)), 20'($urandom_range(0, 8)), 330);
    in_valid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_ticks.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    wait (rst_n);
    forever begin
      stall = draw_gap(calm_out);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_ticks.size() == 0) begin
        $error("result with no request waiting");
        mismatch_count++;
      end else begin
        oldest_tick = pending_ticks.pop_front();
        check_field("trig_level", oldest_tick.trig, out_trig_level);
        check_field("done_res", oldest_tick.done, out_done_res);
        check_field("timed_out", oldest_tick.timed, out_timed_out);
        check_field("distance_cm", oldest_tick.dist_cm, out_distance_cm);
        check_field("angle_deg", oldest_tick.angle, out_angle_deg);
        check_field("servo_compare", oldest_tick.cmp, out_servo_compare);
      end
    end
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
